FILE: src/i2cm_pkg.sv
// Shared types and constants for the I2C master register access block.
`timescale 1ns / 1ps
package i2cm_pkg;
    typedef enum logic [18:0] {
        PH_IDLE       = 19'h00001,
        PH_START_A    = 19'h00002,
        PH_START_B    = 19'h00004,
        PH_RS_A       = 19'h00008,
        PH_RS_B       = 19'h00010,
        PH_RS_C       = 19'h00020,
        PH_WBIT_LO    = 19'h00040,
        PH_WBIT_HI    = 19'h00080,
        PH_ACK_LO     = 19'h00100,
        PH_ACK_SETTLE = 19'h00200,
        PH_ACK_POLL   = 19'h00400,
        PH_ACK_HOLD   = 19'h00800,
        PH_RBIT_LO    = 19'h01000,
        PH_RBIT_HI    = 19'h02000,
        PH_MACK_LO    = 19'h04000,
        PH_MACK_HI    = 19'h08000,
        PH_STOP_A     = 19'h10000,
        PH_STOP_B     = 19'h20000,
        PH_STOP_C     = 19'h40000
    } t_phase;

    localparam logic [1:0] OP_WRITE     = 2'd0;
    localparam logic [1:0] OP_READ      = 2'd1;
    localparam logic [1:0] OP_BURST     = 2'd2;
    localparam logic [1:0] OP_BURST_ALT = 2'd3;
    localparam logic       REQ_TICK = 1'b0;
    localparam logic [0:0] CFG_HALF  = 1'b0;
    localparam logic [0:0] CFG_LIMIT = 1'b1;
    localparam logic [7:0] RST_HALF  = 8'd8;
    localparam logic [7:0] RST_LIMIT = 8'd250;

    typedef struct packed {
        logic       req_type;
        logic [1:0] operation;
        logic [7:0] slave_addr;
        logic [7:0] reg_index;
        logic [7:0] write_data;
        logic [7:0] burst_length;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_release;
        logic       busy_res;
        logic       byte_valid;
        logic [7:0] read_byte;
        logic       last_byte;
        logic       done_res;
        logic       nack_error;
    } t_result;
endpackage

FILE: src/i2cm_front.sv
// Input register stage that captures incoming beats and forwards them to the sequencer.
`timescale 1ns / 1ps
module i2cm_front
    import i2cm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);
    logic  r_full;
    t_item r_item;

    assign o_ready = !r_full || i_ready;
    assign o_valid = r_full;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (o_ready) begin
            r_full <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

`ifndef ASSERT_OFF
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full && !i_ready |=> r_full && $stable(r_item))
        else $error("queued beat lost");
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_full)
        else $error("accepted beat not held");
    a_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_item == $past(i_item))
        else $error("accepted beat altered");
`endif
endmodule

FILE: src/i2cm_back.sv
// Line sequencer that executes one beat per cycle while its output is taken and registers the result.
`timescale 1ns / 1ps
module i2cm_back
    import i2cm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_we,
    input  logic    i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_item   i_item,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);
    t_phase r_phase, n_phase;
    logic [3:0] r_bit, n_bit;
    logic [7:0] r_shift, n_shift, r_left, n_left, r_timer, n_timer, r_poll, n_poll;
    logic [1:0] r_op, n_op, r_stage, n_stage;
    logic [7:0] r_dev, n_dev, r_reg, n_reg, r_dat, n_dat;
    logic r_abort, n_abort;
    logic [7:0] r_half, r_limit, half, limit, tinc;
    logic r_ovalid;
    t_result r_res, n_res;
    logic scl_c, sda_c, fire;

    function automatic logic [1:0] lev(t_phase p, logic [7:0] s, logic [7:0] l);
        logic c, d;
        c = 1'b1;
        d = 1'b1;
        case (p)
            PH_START_B: d = 1'b0;
            PH_RS_A:    c = 1'b0;
            PH_RS_C:    d = 1'b0;
            PH_WBIT_LO: begin c = 1'b0; d = s[7]; end
            PH_WBIT_HI: d = s[7];
            PH_ACK_LO:  c = 1'b0;
            PH_RBIT_LO: c = 1'b0;
            PH_MACK_LO: begin c = 1'b0; d = (l == 8'd1); end
            PH_MACK_HI: d = (l == 8'd1);
            PH_STOP_A:  begin c = 1'b0; d = 1'b0; end
            PH_STOP_B:  d = 1'b0;
            default:    ;
        endcase
        return {c, d};
    endfunction

    assign o_ready = !r_ovalid || i_ready;
    assign fire    = o_ready && i_valid;
    assign o_valid = r_ovalid;
    assign o_res   = r_res;
    assign half    = (r_half == 8'd0) ? 8'd1 : r_half;
    assign limit   = (r_limit == 8'd0) ? 8'd1 : r_limit;
    assign tinc    = r_timer + 8'd1;
    assign {scl_c, sda_c} = lev(r_phase, r_shift, r_left);

    always_comb begin
        n_phase = r_phase; n_bit = r_bit; n_shift = r_shift; n_left = r_left;
        n_timer = r_timer; n_poll = r_poll; n_op = r_op; n_stage = r_stage;
        n_dev = r_dev; n_reg = r_reg; n_dat = r_dat; n_abort = r_abort;
        n_res = '0;
        if (i_item.req_type != REQ_TICK) begin
            if (r_phase == PH_IDLE) begin
                n_op = i_item.operation; n_dev = i_item.slave_addr;
                n_reg = i_item.reg_index; n_dat = i_item.write_data;
                if (i_item.operation == OP_WRITE) n_left = 8'd0;
                else if (i_item.operation == OP_READ) n_left = 8'd1;
                else n_left = (i_item.burst_length == 8'd0) ? 8'd1 : i_item.burst_length;
                n_stage = 2'd0; n_abort = 1'b0; n_poll = 8'd0; n_bit = 4'd0;
                n_shift = 8'd0; n_phase = PH_START_A; n_timer = 8'd0;
            end
        end else if (r_phase == PH_ACK_POLL) begin
            if (!i_item.sda_in) begin
                n_poll = 8'd0; n_phase = PH_ACK_HOLD; n_timer = 8'd0;
            end else begin
                n_poll = r_poll + 8'd1;
                if (n_poll >= limit) begin
                    n_poll = 8'd0; n_abort = 1'b1; n_phase = PH_STOP_A; n_timer = 8'd0;
                end
            end
        end else if (r_phase != PH_IDLE) begin
            n_timer = tinc;
            if (tinc >= half) begin
                n_timer = 8'd0;
                case (r_phase)
                    PH_START_A: n_phase = PH_START_B;
                    PH_START_B: begin
                        n_shift = r_dev & 8'hfe; n_bit = 4'd0; n_phase = PH_WBIT_LO;
                    end
                    PH_RS_A: n_phase = PH_RS_B;
                    PH_RS_B: n_phase = PH_RS_C;
                    PH_RS_C: begin
                        n_stage = 2'd2; n_shift = r_dev | 8'h01; n_bit = 4'd0;
                        n_phase = PH_WBIT_LO;
                    end
                    PH_WBIT_LO: n_phase = PH_WBIT_HI;
                    PH_WBIT_HI: begin
                        n_shift = {r_shift[6:0], 1'b0};
                        n_bit = r_bit + 4'd1;
                        n_phase = (n_bit >= 4'd8) ? PH_ACK_LO : PH_WBIT_LO;
                    end
                    PH_ACK_LO: n_phase = PH_ACK_SETTLE;
                    PH_ACK_SETTLE: begin n_poll = 8'd0; n_phase = PH_ACK_POLL; end
                    PH_ACK_HOLD: begin
                        if (r_stage == 2'd0) begin
                            n_stage = 2'd1; n_shift = r_reg; n_bit = 4'd0;
                            n_phase = PH_WBIT_LO;
                        end else if (r_stage == 2'd1) begin
                            if (r_op == OP_WRITE) begin
                                n_stage = 2'd2; n_shift = r_dat; n_bit = 4'd0;
                                n_phase = PH_WBIT_LO;
                            end else n_phase = PH_RS_A;
                        end else if (r_op == OP_WRITE) n_phase = PH_STOP_A;
                        else begin n_shift = 8'd0; n_bit = 4'd0; n_phase = PH_RBIT_LO; end
                    end
                    PH_RBIT_LO: n_phase = PH_RBIT_HI;
                    PH_RBIT_HI: begin
                        n_shift = {r_shift[6:0], i_item.sda_in};
                        n_bit = r_bit + 4'd1;
                        if (n_bit >= 4'd8) begin
                            n_res.byte_valid = 1'b1; n_res.read_byte = n_shift;
                            n_res.last_byte = (r_left <= 8'd1);
                            if (r_left == 8'd0) n_left = 8'd1;
                            n_phase = PH_MACK_LO;
                        end else n_phase = PH_RBIT_LO;
                    end
                    PH_MACK_LO: n_phase = PH_MACK_HI;
                    PH_MACK_HI: begin
                        n_left = r_left - 8'd1;
                        if (n_left == 8'd0) n_phase = PH_STOP_A;
                        else begin n_shift = 8'd0; n_bit = 4'd0; n_phase = PH_RBIT_LO; end
                    end
                    PH_STOP_A: n_phase = PH_STOP_B;
                    PH_STOP_B: n_phase = PH_STOP_C;
                    PH_STOP_C: begin
                        n_res.done_res = 1'b1; n_res.nack_error = r_abort;
                        n_abort = 1'b0; n_stage = 2'd0; n_phase = PH_IDLE;
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
        end
        n_res.scl_out = scl_c;
        n_res.sda_release = sda_c;
        n_res.busy_res = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_bit <= '0; r_shift <= '0; r_left <= '0;
            r_timer <= '0; r_poll <= '0; r_op <= '0; r_stage <= '0;
            r_dev <= '0; r_reg <= '0; r_dat <= '0; r_abort <= 1'b0;
            r_half <= RST_HALF; r_limit <= RST_LIMIT; r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_HALF) r_half <= i_cfg_data;
                if (i_cfg_idx == CFG_LIMIT) r_limit <= i_cfg_data;
            end
            if (o_ready) r_ovalid <= i_valid;
            if (fire) begin
                r_phase <= n_phase; r_bit <= n_bit; r_shift <= n_shift;
                r_left <= n_left; r_timer <= n_timer; r_poll <= n_poll;
                r_op <= n_op; r_stage <= n_stage; r_dev <= n_dev; r_reg <= n_reg;
                r_dat <= n_dat; r_abort <= n_abort;
            end
        end
        if (fire) r_res <= n_res;
    end

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_res.done_res |-> !r_res.busy_res)
        else $error("done while busy");
    a_err_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_res.nack_error |-> r_res.done_res)
        else $error("error without done");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_res.last_byte |-> r_res.byte_valid)
        else $error("last without byte");
`endif
endmodule

FILE: src/i2c_master_register_access.sv
// Top level of the I2C master register access block.
// A beat's result passes through the input register and then the result register.
// Throughput: one beat per cycle; both stages accept while their output is taken.
// Bit timing is set by the half period configuration value, in tick beats per SCL half period.
// Reset (synchronous, active low) returns the sequencer to idle
// and the configuration to half period 8 and ACK poll limit 250.
`timescale 1ns / 1ps
module i2c_master_register_access
    import i2cm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_req_type,
    input  logic [1:0] i_operation,
    input  logic [7:0] i_slave_addr,
    input  logic [7:0] i_reg_index,
    input  logic [7:0] i_write_data,
    input  logic [7:0] i_burst_length,
    input  logic       i_sda_in,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_scl_out,
    output logic       o_sda_release,
    output logic       o_busy_res,
    output logic       o_byte_valid,
    output logic [7:0] o_read_byte,
    output logic       o_last_byte,
    output logic       o_done_res,
    output logic       o_nack_error
);
    t_item   in_item, q_item;
    t_result res;
    logic    q_valid, q_ready;

    assign in_item = '{i_req_type, i_operation, i_slave_addr, i_reg_index,
                       i_write_data, i_burst_length, i_sda_in};

    i2cm_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_item(in_item),
        .o_valid(q_valid), .i_ready(q_ready), .o_item(q_item)
    );

    i2cm_back u_back (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid(q_valid), .o_ready(q_ready), .i_item(q_item),
        .o_valid, .i_ready, .o_res(res)
    );

    assign o_scl_out     = res.scl_out;
    assign o_sda_release = res.sda_release;
    assign o_busy_res    = res.busy_res;
    assign o_byte_valid  = res.byte_valid;
    assign o_read_byte   = res.read_byte;
    assign o_last_byte   = res.last_byte;
    assign o_done_res    = res.done_res;
    assign o_nack_error  = res.nack_error;
endmodule
